// File: design/clcd_pkg.sv
// Shared types, constants and helpers for the character LCD text/cursor controller.
// No dependencies; used by clcd_valid, the top level and the checker by scoped names.
package clcd_pkg;

    localparam int ROWS    = 2;
    localparam int COLUMNS = 16;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;

    // field widths of the request and result items
    localparam int CMD_W   = 4;
    localparam int CHAR_W  = 8;
    localparam int TROW_W  = 3;
    localparam int TCOL_W  = 6;
    localparam int ROW_W   = 1;
    localparam int COL_W   = 4;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE     = 4'd0,
        CMD_CLEAR     = 4'd1,
        CMD_CLEAR_EOL = 4'd2,
        CMD_UP        = 4'd3,
        CMD_DOWN      = 4'd4,
        CMD_LEFT      = 4'd5,
        CMD_RIGHT     = 4'd6,
        CMD_SET_POS   = 4'd7,
        CMD_READ_CELL = 4'd8
    } t_cmd;

    // control from the sequencer to the cell-valid flags
    typedef struct packed {
        logic              set;
        logic [ADDR_W-1:0] set_addr;
        logic              clr_all;
        logic              clr_eol;
        logic [ROW_W-1:0]  eol_row;
        logic [COL_W-1:0]  eol_col;
    } t_vctl;

    function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
        int idx;
        idx = int'(row) * COLUMNS + int'(col);
        return ADDR_W'(idx);
    endfunction

endpackage

// File: design/clcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/clcd_valid.sv
// Per-cell written flags: a cell without its flag reads as a space.
// Depends on clcd_pkg.
module clcd_valid (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  clcd_pkg::t_vctl               i_ctl,
    input  logic [clcd_pkg::ADDR_W-1:0]   i_addr,
    output logic                          o_valid
);
    localparam int ROW_CMP_W = clcd_pkg::ROW_W;

    logic [clcd_pkg::CELLS-1:0] r_vld;
    logic [clcd_pkg::CELLS-1:0] n_vld;

    always_comb begin
        n_vld = r_vld;
        if (i_ctl.clr_all) begin
            n_vld = '0;
        end
        if (i_ctl.clr_eol) begin
            for (int r = 0; r < clcd_pkg::ROWS; r++) begin
                for (int c = 0; c < clcd_pkg::COLUMNS; c++) begin
                    if (ROW_CMP_W'(r) == ROW_CMP_W'(i_ctl.eol_row) &&
                        c >= int'(i_ctl.eol_col)) begin
                        n_vld[r * clcd_pkg::COLUMNS + c] = 1'b0;
                    end
                end
            end
        end
        if (i_ctl.set) begin
            n_vld[i_ctl.set_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[i_addr];

endmodule

// File: design/char_lcd_text_cursor_controller.sv
// Character LCD text store with cursor: accepts one command request at a time and returns
// one result per request. The request is taken in S_IDLE and its result is registered from
// S_GLYPH, with S_CELL in between for read_cell with a valid position, since the target cell
// and the cell under the cursor are both fetched through the single read port of the text RAM.
// A new request is taken only once the block is back in S_IDLE after the last result.
// Clear and clear-to-end-of-row finish in one step because each cell carries a written flag
// that resets to "space". A result waits in the output register; the next request is taken
// while it waits, but its own result holds the block busy until that register frees.
// Depends on clcd_pkg, clcd_ram and clcd_valid.
module char_lcd_text_cursor_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [3:0] cmd, [11:4] char_code, [14:12] target_row, [20:15] target_column, [23:21] zero
    input  logic [clcd_pkg::S_DATA_W-1:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [0] ok, [1] cursor_row, [5:2] cursor_column, [13:6] cursor_glyph,
    // [21:14] cell_char, [23:22] zero
    output logic [clcd_pkg::M_DATA_W-1:0] o_m_tdata
);
    typedef enum logic [1:0] {S_IDLE, S_CELL, S_GLYPH} t_state;

    localparam int AW = clcd_pkg::ADDR_W;
    localparam int CW = clcd_pkg::CHAR_W;

    t_state r_state, n_state;
    logic [clcd_pkg::ROW_W-1:0] r_row, n_row;
    logic [clcd_pkg::COL_W-1:0] r_col, n_col;
    logic          r_ok, n_ok;
    logic [CW-1:0] r_cell, n_cell;
    logic [AW-1:0] r_rd_addr, n_rd_addr;
    logic          r_fwd, n_fwd;
    logic [CW-1:0] r_fwd_data, n_fwd_data;
    logic          r_m_valid, n_m_valid;
    logic [clcd_pkg::M_DATA_W-1:0] r_m_data, n_m_data;

    logic [clcd_pkg::CMD_W-1:0]  in_cmd;
    logic [CW-1:0]               in_char;
    logic [clcd_pkg::TROW_W-1:0] in_trow;
    logic [clcd_pkg::TCOL_W-1:0] in_tcol;

    logic          s_acc;
    logic          tgt_ok;
    logic [AW-1:0] tgt_addr;
    logic [AW-1:0] cur_addr;
    logic          ram_we;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [CW-1:0] ram_rdata;
    logic          cell_vld;
    logic [CW-1:0] stored;
    logic [CW-1:0] gbyte;
    logic [CW-1:0] glyph;
    logic          acc_ok;
    logic          rd_tgt;
    clcd_pkg::t_vctl vctl;

    assign in_cmd  = i_s_tdata[3:0];
    assign in_char = i_s_tdata[11:4];
    assign in_trow = i_s_tdata[14:12];
    assign in_tcol = i_s_tdata[20:15];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;

    assign tgt_ok   = (int'(in_trow) < clcd_pkg::ROWS) && (int'(in_tcol) < clcd_pkg::COLUMNS);
    assign tgt_addr = clcd_pkg::addr_of(in_trow[clcd_pkg::ROW_W-1:0],
                                        in_tcol[clcd_pkg::COL_W-1:0]);
    assign cur_addr = clcd_pkg::addr_of(r_row, r_col);

    // command decode for the accepted request
    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        acc_ok = 1'b0;
        ram_we = 1'b0;
        rd_tgt = 1'b0;
        vctl   = '0;
        vctl.set_addr = cur_addr;
        vctl.eol_row  = r_row;
        vctl.eol_col  = r_col;
        case (clcd_pkg::t_cmd'(in_cmd))
            clcd_pkg::CMD_WRITE: begin
                ram_we   = s_acc;
                vctl.set = s_acc;
                acc_ok   = 1'b1;
                if (int'(r_col) + 1 < clcd_pkg::COLUMNS) begin
                    n_col = r_col + 1'b1;
                end else if (int'(r_row) + 1 >= clcd_pkg::ROWS) begin
                    n_row = '0;
                    n_col = '0;
                end else begin
                    n_row = r_row + 1'b1;
                    n_col = '0;
                end
            end
            clcd_pkg::CMD_CLEAR: begin
                vctl.clr_all = s_acc;
                n_row  = '0;
                n_col  = '0;
                acc_ok = 1'b1;
            end
            clcd_pkg::CMD_CLEAR_EOL: begin
                vctl.clr_eol = s_acc;
                acc_ok = 1'b1;
            end
            clcd_pkg::CMD_UP: begin
                if (r_row != '0) begin
                    n_row  = r_row - 1'b1;
                    acc_ok = 1'b1;
                end
            end
            clcd_pkg::CMD_DOWN: begin
                if (int'(r_row) + 1 < clcd_pkg::ROWS) begin
                    n_row  = r_row + 1'b1;
                    acc_ok = 1'b1;
                end
            end
            clcd_pkg::CMD_LEFT: begin
                if (r_col != '0) begin
                    n_col  = r_col - 1'b1;
                    acc_ok = 1'b1;
                end
            end
            clcd_pkg::CMD_RIGHT: begin
                if (int'(r_col) + 1 < clcd_pkg::COLUMNS) begin
                    n_col  = r_col + 1'b1;
                    acc_ok = 1'b1;
                end
            end
            clcd_pkg::CMD_SET_POS: begin
                if (tgt_ok) begin
                    n_row  = in_trow[clcd_pkg::ROW_W-1:0];
                    n_col  = in_tcol[clcd_pkg::COL_W-1:0];
                    acc_ok = 1'b1;
                end
            end
            clcd_pkg::CMD_READ_CELL: begin
                if (tgt_ok) begin
                    rd_tgt = 1'b1;
                    acc_ok = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // read the target cell first for read_cell, otherwise the cell under the new cursor
    always_comb begin
        if (s_acc) begin
            ram_raddr = rd_tgt ? tgt_addr : clcd_pkg::addr_of(n_row, n_col);
        end else begin
            ram_raddr = cur_addr;
        end
    end
    assign ram_re = s_acc || (r_state == S_CELL);

    clcd_ram #(
        .WIDTH (CW),
        .DEPTH (clcd_pkg::CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (cur_addr),
        .i_wdata (in_char),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    clcd_valid u_valid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (vctl),
        .i_addr  (r_rd_addr),
        .o_valid (cell_vld)
    );

    assign stored = cell_vld ? ram_rdata : clcd_pkg::CH_SPACE;
    // a write that lands on the cell being read returns the new byte
    assign gbyte  = r_fwd ? r_fwd_data : stored;
    assign glyph  = (gbyte == clcd_pkg::CH_SPACE || gbyte == '0) ?
                    clcd_pkg::CH_UNDERSCORE : gbyte;

    always_comb begin
        n_state    = r_state;
        n_ok       = r_ok;
        n_cell     = r_cell;
        n_rd_addr  = r_rd_addr;
        n_fwd      = r_fwd;
        n_fwd_data = r_fwd_data;
        n_m_valid  = r_m_valid && !i_m_tready;
        n_m_data   = r_m_data;
        if (ram_re) begin
            n_rd_addr = ram_raddr;
        end
        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    n_ok       = acc_ok;
                    n_cell     = '0;
                    n_fwd      = ram_we && (cur_addr == ram_raddr);
                    n_fwd_data = in_char;
                    n_state    = rd_tgt ? S_CELL : S_GLYPH;
                end
            end
            S_CELL: begin
                n_cell  = stored;
                n_fwd   = 1'b0;
                n_state = S_GLYPH;
            end
            S_GLYPH: begin
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {2'b00, r_cell, glyph, r_col, r_row, r_ok};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row     <= '0;
            r_col     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= (r_state == S_IDLE && s_acc) ? n_row : r_row;
            r_col     <= (r_state == S_IDLE && s_acc) ? n_col : r_col;
            r_m_valid <= n_m_valid;
        end
        r_ok       <= n_ok;
        r_cell     <= n_cell;
        r_rd_addr  <= n_rd_addr;
        r_fwd      <= n_fwd;
        r_fwd_data <= n_fwd_data;
        r_m_data   <= n_m_data;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

// File: design/clcd_checker.sv
// Port-level checks for the character LCD text/cursor controller, bound to the top level.
// Depends on clcd_pkg and char_lcd_text_cursor_controller.
module clcd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_s_tvalid,
    input logic                          o_s_tready,
    input logic [clcd_pkg::S_DATA_W-1:0] i_s_tdata,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [clcd_pkg::M_DATA_W-1:0] o_m_tdata
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no request taken in the cycle after one
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("request taken while busy");

    // the glyph is never a blank
    a_glyph: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[13:6] != clcd_pkg::CH_SPACE) && (o_m_tdata[13:6] != 8'h00))
        else $error("blank cursor glyph");

    // a cell byte is only reported by a successful read
    a_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[21:14] != 8'h00) |-> o_m_tdata[0])
        else $error("cell byte without ok");

endmodule

bind char_lcd_text_cursor_controller clcd_checker u_clcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
